>>> sv/bps_pkg.sv
// Shared types and constants for the beep pattern sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package bps_pkg;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_PATTERN = 2'd1;
  localparam logic [1:0] MODE_EVENT   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] REG_MASTER_ENABLE = 2'd0;
  localparam logic [1:0] REG_EVENT_MASK    = 2'd1;
  localparam logic [1:0] REG_DEFAULT_VOL   = 2'd2;

  localparam logic [13:0] MIN_TONE    = 14'd100;
  localparam logic [13:0] MAX_TONE    = 14'd10000;
  localparam logic [6:0]  MAX_VOL     = 7'd100;
  localparam logic [6:0]  MIN_VOL     = 7'd1;
  localparam logic [6:0]  RESET_VOL   = 7'd40;
  localparam logic [3:0]  EVENT_COUNT = 4'd9;

  localparam int DUTY_W      = 10;
  localparam int VOL_ENTRIES = 128;

  typedef struct packed {
    logic        start;
    logic        tick;
    logic [13:0] hz;
    logic [6:0]  beats;
    logic [15:0] on_ms;
    logic [15:0] gap_ms;
    logic [9:0]  duty;
  } bps_cmd_t;

  typedef struct packed {
    logic        running;
    logic        sounding;
    logic [13:0] freq;
    logic [9:0]  duty;
  } bps_view_t;

endpackage

`default_nettype wire

>>> sv/bps_req_check.sv
// Request decode: gating, argument range checks and duty lookup.
// Depends on bps_pkg.
`default_nettype none

module bps_req_check
  import bps_pkg::*;
#(
  parameter int MAX_BEATS    = 100,
  parameter int MAX_PHASE_MS = 60000,
  parameter int DUTY_BITS    = 10
) (
  input  wire logic [1:0]  mode,
  input  wire logic [3:0]  event_code,
  input  wire logic [13:0] tone_hz,
  input  wire logic [6:0]  beat_count,
  input  wire logic [15:0] on_ms,
  input  wire logic [15:0] gap_len_ms,
  input  wire logic [6:0]  volume,
  input  wire logic        master_enable,
  input  wire logic [8:0]  event_enable_mask,
  input  wire logic [6:0]  default_volume,
  input  wire logic        running,
  output bps_cmd_t         cmd,
  output logic [1:0]       status
);

  function automatic logic [VOL_ENTRIES*DUTY_W-1:0] build_duty_table();
    logic [VOL_ENTRIES*DUTY_W-1:0] t;
    int half;
    half = 1 << (DUTY_BITS - 1);
    t = '0;
    for (int i = 0; i < VOL_ENTRIES; i++) begin
      t[i*DUTY_W +: DUTY_W] = DUTY_W'((half * i + 99) / 100);
    end
    return t;
  endfunction

  localparam logic [VOL_ENTRIES*DUTY_W-1:0] DUTY_TABLE = build_duty_table();

  logic [6:0] vol_sel;
  logic       args_ok;
  logic       gated;

  assign vol_sel = (mode == MODE_EVENT) ? default_volume : volume;

  assign args_ok = (tone_hz >= MIN_TONE) && (tone_hz <= MAX_TONE) &&
                   (beat_count != 7'd0) && (beat_count <= 7'(MAX_BEATS)) &&
                   (on_ms != 16'd0) && (on_ms <= 16'(MAX_PHASE_MS)) &&
                   (gap_len_ms <= 16'(MAX_PHASE_MS)) &&
                   (vol_sel != 7'd0) && (vol_sel <= MAX_VOL);

  assign gated = !master_enable || (event_code >= EVENT_COUNT) ||
                 !event_enable_mask[event_code];

  always_comb begin
    cmd.start  = 1'b0;
    cmd.tick   = 1'b0;
    cmd.hz     = tone_hz;
    cmd.beats  = beat_count;
    cmd.on_ms  = on_ms;
    cmd.gap_ms = gap_len_ms;
    cmd.duty   = DUTY_TABLE[vol_sel*DUTY_W +: DUTY_W];
    status     = ST_OK;
    unique case (mode)
      MODE_TICK: begin
        cmd.tick = 1'b1;
      end
      MODE_PATTERN, MODE_EVENT: begin
        if ((mode == MODE_EVENT) && gated) begin
          status = ST_REFUSED;
        end else if (!args_ok) begin
          status = ST_INVALID;
        end else if (running) begin
          status = ST_REFUSED;
        end else begin
          cmd.start = 1'b1;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/bps_seq.sv
// Pattern state: beat and phase counters, held tone settings.
// Depends on bps_pkg; driven by decoded commands from bps_req_check.
`default_nettype none

module bps_seq
  import bps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  bps_cmd_t  cmd,
  output logic      running,
  output bps_view_t view_next
);

  logic        in_gap, in_gap_next;
  logic        running_next;
  logic [6:0]  beats_left, beats_left_next;
  logic [15:0] phase_ms_left, phase_ms_left_next;
  logic [15:0] held_on_ms, held_on_ms_next;
  logic [15:0] held_gap_ms, held_gap_ms_next;
  logic [13:0] held_freq, held_freq_next;
  logic [9:0]  held_duty, held_duty_next;
  logic [6:0]  beats_dec;

  assign beats_dec = (beats_left != 7'd0) ? beats_left - 7'd1 : 7'd0;

  always_comb begin
    running_next       = running;
    in_gap_next        = in_gap;
    beats_left_next    = beats_left;
    phase_ms_left_next = phase_ms_left;
    held_on_ms_next    = held_on_ms;
    held_gap_ms_next   = held_gap_ms;
    held_freq_next     = held_freq;
    held_duty_next     = held_duty;
    if (cmd.start) begin
      running_next       = 1'b1;
      in_gap_next        = 1'b0;
      beats_left_next    = cmd.beats;
      phase_ms_left_next = cmd.on_ms;
      held_on_ms_next    = cmd.on_ms;
      held_gap_ms_next   = cmd.gap_ms;
      held_freq_next     = cmd.hz;
      held_duty_next     = cmd.duty;
    end else if (cmd.tick && running) begin
      if (phase_ms_left > 16'd1) begin
        phase_ms_left_next = phase_ms_left - 16'd1;
      end else if (in_gap) begin
        in_gap_next        = 1'b0;
        phase_ms_left_next = held_on_ms;
      end else begin
        beats_left_next = beats_dec;
        if (beats_dec == 7'd0) begin
          running_next       = 1'b0;
          phase_ms_left_next = 16'd0;
        end else if (held_gap_ms != 16'd0) begin
          in_gap_next        = 1'b1;
          phase_ms_left_next = held_gap_ms;
        end else begin
          phase_ms_left_next = held_on_ms;
        end
      end
    end
  end

  always_comb begin
    view_next.running  = running_next;
    view_next.sounding = running_next && !in_gap_next;
    view_next.freq     = view_next.sounding ? held_freq_next : 14'd0;
    view_next.duty     = view_next.sounding ? held_duty_next : 10'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      in_gap        <= 1'b0;
      beats_left    <= 7'd0;
      phase_ms_left <= 16'd0;
      held_on_ms    <= 16'd0;
      held_gap_ms   <= 16'd0;
      held_freq     <= 14'd0;
      held_duty     <= 10'd0;
    end else if (advance) begin
      running       <= running_next;
      in_gap        <= in_gap_next;
      beats_left    <= beats_left_next;
      phase_ms_left <= phase_ms_left_next;
      held_on_ms    <= held_on_ms_next;
      held_gap_ms   <= held_gap_ms_next;
      held_freq     <= held_freq_next;
      held_duty     <= held_duty_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/beep_pattern_sequencer_unit.sv
// Beep pattern sequencer top level: input register, decode, state, result register.
// An accepted item is held in the input register and its result is then registered; out_stall can hold either.
// Throughput: one item per cycle while out_stall does not hold; set by the single decode and state update pass.
// Reset (rst, synchronous): pipeline empty, pattern idle, registers at their
// reset values (enable 1, event mask all ones, default volume 40).
// Depends on bps_pkg, bps_req_check and bps_seq.
`default_nettype none

module beep_pattern_sequencer_unit
  import bps_pkg::*;
#(
  parameter int MAX_BEATS    = 100,
  parameter int MAX_PHASE_MS = 60000,
  parameter int DUTY_BITS    = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [3:0]  event_code,
  input  wire logic [13:0] tone_hz,
  input  wire logic [6:0]  beat_count,
  input  wire logic [15:0] on_ms,
  input  wire logic [15:0] gap_len_ms,
  input  wire logic [6:0]  volume,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic             tone_on,
  output logic [13:0]      tone_frequency,
  output logic [9:0]       duty,
  output logic             busy_res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  logic        master_enable;
  logic [8:0]  event_enable_mask;
  logic [6:0]  default_volume;
  logic [6:0]  vol_clamped;

  logic        in_full;
  logic [1:0]  mode_q;
  logic [3:0]  event_q;
  logic [13:0] hz_q;
  logic [6:0]  beats_q;
  logic [15:0] on_q;
  logic [15:0] gap_q;
  logic [6:0]  vol_q;

  logic        advance;
  logic        running;
  bps_cmd_t    cmd;
  logic [1:0]  status_next;
  bps_view_t   view_next;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_comb begin
    vol_clamped = cfg_data[6:0];
    if (vol_clamped < MIN_VOL) begin
      vol_clamped = MIN_VOL;
    end else if (vol_clamped > MAX_VOL) begin
      vol_clamped = MAX_VOL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_enable     <= 1'b1;
      event_enable_mask <= 9'h1FF;
      default_volume    <= RESET_VOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASTER_ENABLE: master_enable     <= cfg_data[0];
        REG_EVENT_MASK:    event_enable_mask <= cfg_data;
        REG_DEFAULT_VOL:   default_volume    <= vol_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_q  <= mode;
      event_q <= event_code;
      hz_q    <= tone_hz;
      beats_q <= beat_count;
      on_q    <= on_ms;
      gap_q   <= gap_len_ms;
      vol_q   <= volume;
    end
  end

  bps_req_check #(
    .MAX_BEATS    (MAX_BEATS),
    .MAX_PHASE_MS (MAX_PHASE_MS),
    .DUTY_BITS    (DUTY_BITS)
  ) u_check (
    .mode              (mode_q),
    .event_code        (event_q),
    .tone_hz           (hz_q),
    .beat_count        (beats_q),
    .on_ms             (on_q),
    .gap_len_ms        (gap_q),
    .volume            (vol_q),
    .master_enable     (master_enable),
    .event_enable_mask (event_enable_mask),
    .default_volume    (default_volume),
    .running           (running),
    .cmd               (cmd),
    .status            (status_next)
  );

  bps_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cmd       (cmd),
    .running   (running),
    .view_next (view_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status         <= status_next;
      tone_on        <= view_next.sounding;
      tone_frequency <= view_next.freq;
      duty           <= view_next.duty;
      busy_res       <= view_next.running;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_beep_pattern_sequencer_unit.sv
// Self-checking testbench for beep_pattern_sequencer_unit: directed and random items,
// each result checked against a cycle-free predictor of tick, request and register behavior.
// Depends on bps_pkg and the beep_pattern_sequencer_unit RTL.
`timescale 1ns / 1ps

module tb_beep_pattern_sequencer_unit;
  import bps_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int BEAT_LIMIT  = 100;
  localparam int PHASE_LIMIT = 60000;
  localparam int PERCENT     = 100;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  m;
    logic [3:0]  ev;
    logic [13:0] hz;
    logic [6:0]  beats;
    logic [15:0] on;
    logic [15:0] gap;
    logic [6:0]  vol;
  } beep_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        tone_on;
    logic [13:0] freq;
    logic [9:0]  duty;
    logic        busy;
  } beep_result_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_TICK;
  logic [3:0]  event_code = '0;
  logic [13:0] tone_hz = '0;
  logic [6:0]  beat_count = '0;
  logic [15:0] on_ms = '0;
  logic [15:0] gap_len_ms = '0;
  logic [6:0]  volume = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        tone_on;
  logic [13:0] tone_frequency;
  logic [9:0]  duty;
  logic        busy_res;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  // predictor state and register copies
  logic        en_master;
  logic [8:0]  ev_mask;
  logic [6:0]  def_vol;
  logic        run_on;
  logic        gap_phase;
  logic [6:0]  beats_rem;
  logic [15:0] phase_rem;
  logic [15:0] hold_on;
  logic [15:0] hold_gap;
  logic [13:0] hold_freq;
  logic [9:0]  hold_duty;

  beep_result_t result_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          steady = 1'b0;
  int          burst_left = 0;
  rx_style_t   rx_style = RX_FREE;
  int          rx_left = 0;
  int          rx_run = 0;

  beep_pattern_sequencer_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .event_code     (event_code),
    .tone_hz        (tone_hz),
    .beat_count     (beat_count),
    .on_ms          (on_ms),
    .gap_len_ms     (gap_len_ms),
    .volume         (volume),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .tone_on        (tone_on),
    .tone_frequency (tone_frequency),
    .duty           (duty),
    .busy_res       (busy_res),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("beep_pattern_sequencer_unit regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(64, 256);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run == 0) begin
          out_stall <= ~out_stall;
          rx_run <= $urandom_range(1, 6);
        end else begin
          rx_run <= rx_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin : check_results
    beep_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = result_q.pop_front();
        if (status !== want.status || tone_on !== want.tone_on ||
            tone_frequency !== want.freq || duty !== want.duty || busy_res !== want.busy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d (expected/actual): status %0d/%0d tone_on %0b/%0b",
                     cycles, want.status, status, want.tone_on, tone_on,
                     " freq %0d/%0d duty %0d/%0d busy %0b/%0b",
                     want.freq, tone_frequency, want.duty, duty, want.busy, busy_res);
        end
      end
    end
  end

  function automatic void reset_model();
    en_master = 1'b1;
    ev_mask   = 9'h1FF;
    def_vol   = RESET_VOL;
    run_on    = 1'b0;
    gap_phase = 1'b0;
    beats_rem = '0;
    phase_rem = '0;
    hold_on   = '0;
    hold_gap  = '0;
    hold_freq = '0;
    hold_duty = '0;
  endfunction

  function automatic void advance_ms();
    if (!run_on) return;
    if (phase_rem > 1) begin
      phase_rem--;
      return;
    end
    phase_rem = '0;
    if (gap_phase) begin
      gap_phase = 1'b0;
      phase_rem = hold_on;
      return;
    end
    if (beats_rem > 0) beats_rem--;
    if (beats_rem == 0) begin
      run_on = 1'b0;
      return;
    end
    if (hold_gap > 0) begin
      gap_phase = 1'b1;
      phase_rem = hold_gap;
    end else begin
      phase_rem = hold_on;
    end
  endfunction

  function automatic logic [1:0] start_pattern(beep_req_t r, logic [6:0] vol);
    if (r.hz < MIN_TONE || r.hz > MAX_TONE || r.beats == 0 || r.beats > BEAT_LIMIT ||
        r.on == 0 || r.on > PHASE_LIMIT || r.gap > PHASE_LIMIT ||
        vol == 0 || vol > MAX_VOL)
      return ST_INVALID;
    if (run_on) return ST_REFUSED;
    run_on    = 1'b1;
    gap_phase = 1'b0;
    beats_rem = r.beats;
    phase_rem = r.on;
    hold_on   = r.on;
    hold_gap  = r.gap;
    hold_freq = r.hz;
    hold_duty = 10'(((1 << (DUTY_W - 1)) * int'(vol) + PERCENT - 1) / PERCENT);
    return ST_OK;
  endfunction

  function automatic beep_result_t predict_result(beep_req_t r);
    beep_result_t res;
    res.status = ST_OK;
    case (r.m)
      MODE_TICK:    advance_ms();
      MODE_PATTERN: res.status = start_pattern(r, r.vol);
      MODE_EVENT: begin
        if (!en_master || r.ev >= EVENT_COUNT || !ev_mask[r.ev]) res.status = ST_REFUSED;
        else res.status = start_pattern(r, def_vol);
      end
      default:      res.status = ST_INVALID;
    endcase
    res.tone_on = run_on && !gap_phase;
    res.freq    = res.tone_on ? hold_freq : '0;
    res.duty    = res.tone_on ? hold_duty : '0;
    res.busy    = run_on;
    return res;
  endfunction

  function automatic beep_req_t random_payload();
    beep_req_t r;
    r.m     = 2'($urandom);
    r.ev    = 4'($urandom);
    r.hz    = 14'($urandom);
    r.beats = 7'($urandom);
    r.on    = 16'($urandom);
    r.gap   = 16'($urandom);
    r.vol   = 7'($urandom);
    return r;
  endfunction

  function automatic beep_req_t tick_req();
    beep_req_t r;
    r = random_payload();
    r.m = MODE_TICK;
    return r;
  endfunction

  function automatic beep_req_t pattern_req(int hz, int beats, int on, int gap, int vol);
    beep_req_t r;
    r = random_payload();
    r.m     = MODE_PATTERN;
    r.hz    = 14'(hz);
    r.beats = 7'(beats);
    r.on    = 16'(on);
    r.gap   = 16'(gap);
    r.vol   = 7'(vol);
    return r;
  endfunction

  function automatic beep_req_t event_req(int ev, int hz, int beats, int on, int gap);
    beep_req_t r;
    r = pattern_req(hz, beats, on, gap, $urandom);
    r.m  = MODE_EVENT;
    r.ev = 4'(ev);
    return r;
  endfunction

  function automatic logic [1:0] req_mode();
    return ($urandom_range(0, 2) == 0) ? MODE_EVENT : MODE_PATTERN;
  endfunction

  // short_run keeps a started pattern short: at most four short beats, or beats with the shortest on phase
  function automatic beep_req_t well_formed(logic [1:0] m, bit short_run);
    beep_req_t r;
    r = random_payload();
    r.m   = m;
    r.ev  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
    r.hz  = 14'($urandom_range(MIN_TONE, MAX_TONE));
    r.vol = 7'($urandom_range(MIN_VOL, MAX_VOL));
    if (!short_run) begin
      r.beats = 7'($urandom_range(1, BEAT_LIMIT));
      r.on    = 16'($urandom_range(1, PHASE_LIMIT));
      r.gap   = 16'($urandom_range(0, PHASE_LIMIT));
    end else if ($urandom_range(0, 15) == 0) begin
      r.beats = 7'($urandom_range(1, BEAT_LIMIT));
      r.on    = 16'd1;
      r.gap   = 16'($urandom_range(0, 1));
    end else begin
      r.beats = 7'($urandom_range(1, 4));
      r.on    = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6));
      r.gap   = 16'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
    end
    return r;
  endfunction

  function automatic int bad_value(int lo_ok, int hi_ok, int top);
    int side;
    side = (lo_ok == 0) ? 1 : $urandom_range(0, 1);
    if (side == 0) begin
      case ($urandom_range(0, 2))
        0:       return lo_ok - 1;
        1:       return 0;
        default: return $urandom_range(0, lo_ok - 1);
      endcase
    end
    case ($urandom_range(0, 2))
      0:       return hi_ok + 1;
      1:       return top;
      default: return $urandom_range(hi_ok + 1, top);
    endcase
  endfunction

  // event items take the register volume, so break one of the other fields
  function automatic beep_req_t broken(beep_req_t r);
    case ($urandom_range(0, (r.m == MODE_EVENT) ? 3 : 4))
      0:       r.hz    = 14'(bad_value(MIN_TONE, MAX_TONE, 16383));
      1:       r.beats = 7'(bad_value(1, BEAT_LIMIT, 127));
      2:       r.on    = 16'(bad_value(1, PHASE_LIMIT, 65535));
      3:       r.gap   = 16'(bad_value(0, PHASE_LIMIT, 65535));
      default: r.vol   = 7'(bad_value(MIN_VOL, MAX_VOL, 127));
    endcase
    if (r.m == MODE_EVENT) r.ev = 4'($urandom_range(0, 8));
    return r;
  endfunction

  function automatic beep_req_t traffic_item();
    beep_req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (run_on) begin
      if (roll < 80) begin
        r = tick_req();
      end else begin
        r = well_formed(req_mode(), 1'b0);
        if (roll < 90) r = broken(r);
      end
    end else if (roll < 60) begin
      r = well_formed(req_mode(), 1'b1);
    end else if (roll < 72) begin
      r = tick_req();
    end else if (roll < 88) begin
      r = broken(well_formed(req_mode(), 1'b0));
    end else begin
      r = random_payload();
      if (roll < 94) r.m = MODE_UNUSED;
      else if (r.m == MODE_PATTERN || r.m == MODE_EVENT) r = broken(r);
    end
    return r;
  endfunction

  task automatic send_item(input beep_req_t r);
    if (!steady && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid   = 1'b1;
    mode       = r.m;
    event_code = r.ev;
    tone_hz    = r.hz;
    beat_count = r.beats;
    on_ms      = r.on;
    gap_len_ms = r.gap;
    volume     = r.vol;
    do @(posedge clk); while (in_stall);
    result_q.push_back(predict_result(r));
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic finish_pattern();
    while (run_on) send_item(tick_req());
    wait_quiet();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    logic [6:0] v;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MASTER_ENABLE: en_master = data[0];
      REG_EVENT_MASK:    ev_mask = data;
      REG_DEFAULT_VOL: begin
        v = data[6:0];
        if (v < MIN_VOL) v = MIN_VOL;
        if (v > MAX_VOL) v = MAX_VOL;
        def_vol = v;
      end
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [8:0] en, input logic [8:0] mask,
                                input logic [8:0] vol);
    wait_quiet();
    write_reg(REG_MASTER_ENABLE, en);
    write_reg(REG_EVENT_MASK, mask);
    write_reg(REG_DEFAULT_VOL, vol);
  endtask

  task automatic test_idle_items();
    send_item(tick_req());
    send_item(pattern_req(1000, 1, 1, 0, 50) ^ {MODE_PATTERN ^ MODE_UNUSED, 64'd0});
  endtask

  task automatic test_pattern_timing();
    send_item(pattern_req(MIN_TONE, 1, 1, 0, MIN_VOL));
    finish_pattern();
    send_item(pattern_req(MAX_TONE, 2, 2, 0, MAX_VOL));
    finish_pattern();
    // no gap after the last beat
    send_item(pattern_req(440, 2, 1, 2, 50));
    finish_pattern();
  endtask

  task automatic test_request_checks();
    send_item(event_req(0, 1000, 1, 3, 0));
    send_item(pattern_req(MAX_TONE, BEAT_LIMIT, PHASE_LIMIT, PHASE_LIMIT, MAX_VOL));
    send_item(pattern_req(MIN_TONE - 1, 1, 1, 0, 50));
    send_item(event_req(9, 1000, 1, 1, 0));
    finish_pattern();
    send_item(pattern_req(1000, BEAT_LIMIT + 1, 1, 0, 50));
    send_item(pattern_req(1000, 1, 0, 0, 50));
    send_item(pattern_req(1000, 1, 1, PHASE_LIMIT + 1, 50));
    send_item(pattern_req(1000, 1, 1, 0, 127));
    send_item(event_req(15, 1000, 1, 1, 0));
    wait_quiet();
  endtask

  task automatic test_register_writes();
    write_settings(9'h002, 9'h1FF, 9'd40);
    send_item(event_req(4, 2000, 1, 1, 0));
    write_settings(9'h1FF, 9'h100, 9'd40);
    send_item(event_req(0, 2000, 1, 1, 0));
    send_item(event_req(8, 2000, 1, 1, 0));
    finish_pattern();
    write_reg(REG_DEFAULT_VOL, 9'h000);
    send_item(event_req(8, 3000, 1, 1, 0));
    finish_pattern();
    write_reg(REG_DEFAULT_VOL, 9'h1FF);
    write_reg(REG_UNUSED, 9'h000);
    send_item(event_req(8, 3000, 1, 1, 0));
    finish_pattern();
  endtask

  task automatic test_random_traffic(input int budget, input bit no_gaps);
    beep_req_t r;
    int counted;
    counted = 0;
    steady = no_gaps;
    while (counted < budget) begin
      r = traffic_item();
      if (r.m != MODE_TICK || run_on) counted++;
      send_item(r);
    end
    steady = 1'b0;
    finish_pattern();
  endtask

  task automatic test_long_pattern();
    send_item(pattern_req(MAX_TONE, BEAT_LIMIT, PHASE_LIMIT, PHASE_LIMIT, MAX_VOL));
    repeat (12) send_item(tick_req());
    wait_quiet();
  endtask

  initial begin
    reset_model();
    repeat (7) @(negedge clk);
    rst = 1'b0;
    test_idle_items();
    test_pattern_timing();
    test_request_checks();
    test_register_writes();
    write_settings(9'h001, 9'h1FF, 9'($urandom_range(1, 100)));
    test_random_traffic(325, 1'b0);
    write_settings(9'h000, 9'($urandom), 9'h000);
    test_random_traffic(325, 1'b1);
    write_settings(9'h001, 9'($urandom), 9'($urandom));
    test_random_traffic(325, 1'b0);
    write_settings(9'h001, 9'h000, 9'd100);
    test_random_traffic(325, 1'b0);
    test_long_pattern();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("beep_pattern_sequencer_unit regression: pass");
    end else begin
      $display("beep_pattern_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule
